// ----- hdl/vprf_pkg.sv -----
// Shared types and constants for the video port register file.
`timescale 1ns / 1ps
package vprf_pkg;
   localparam int NAMETABLE_BYTES  = 4096;
   localparam int PATTERN_BYTES    = 8192;
   localparam int SPRITE_MEM_BYTES = 256;
   localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
   localparam int PAT_AW = $clog2(PATTERN_BYTES);
   localparam int SPR_AW = $clog2(SPRITE_MEM_BYTES);

   typedef enum logic [2:0] {
      FUNC_READ    = 3'd0,
      FUNC_WRITE   = 3'd1,
      FUNC_FRAME   = 3'd2,
      FUNC_LINE    = 3'd3,
      FUNC_VBL_ON  = 3'd4,
      FUNC_VBL_OFF = 3'd5
   } func_type;

   localparam logic [2:0] PORT_CTRL   = 3'd0;
   localparam logic [2:0] PORT_MASK   = 3'd1;
   localparam logic [2:0] PORT_STATUS = 3'd2;
   localparam logic [2:0] PORT_SPADDR = 3'd3;
   localparam logic [2:0] PORT_SPDATA = 3'd4;
   localparam logic [2:0] PORT_SCROLL = 3'd5;
   localparam logic [2:0] PORT_ADDR   = 3'd6;
   localparam logic [2:0] PORT_DATA   = 3'd7;

   // video memory region of a data port access
   localparam logic [1:0] REGION_PAT = 2'd0;
   localparam logic [1:0] REGION_NT  = 2'd1;
   localparam logic [1:0] REGION_PAL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic issue;   // capture item, launch memory read
      logic finish;  // apply memory data, emit result
   } cmd_type;
endpackage

// ----- hdl/vprf_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module vprf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule

// ----- hdl/vprf_ctrl.sv -----
// Sequencing controller: accept, memory read cycle, result.
`timescale 1ns / 1ps
module vprf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output vprf_pkg::cmd_type  cmd
);
   vprf_pkg::state_type state_ff, state_in;
   always_ff @(posedge clock) begin
      if (reset) state_ff <= vprf_pkg::ST_IDLE;
      else state_ff <= state_in;
   end
   always_comb begin
      state_in   = state_ff;
      cmd.issue  = 1'b0;
      cmd.finish = 1'b0;
      busy       = 1'b1;
      unique case (state_ff)
         vprf_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.issue = 1'b1;
               state_in  = vprf_pkg::ST_EXEC;
            end
         end
         vprf_pkg::ST_EXEC: begin
            cmd.finish = 1'b1;
            state_in   = vprf_pkg::ST_IDLE;
         end
         default: state_in = vprf_pkg::ST_IDLE;
      endcase
   end
endmodule

// ----- hdl/vprf_datapath.sv -----
// Register, scroll latch and memory datapath.
`timescale 1ns / 1ps
module vprf_datapath (
   input  logic              clock,
   input  logic              reset,
   input  vprf_pkg::cmd_type cmd,
   input  logic [2:0]        req_func,
   input  logic [2:0]        req_port_index,
   input  logic [7:0]        req_write_data,
   input  logic [7:0]        nt_map,
   output logic              rsp_valid,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_vblank_active,
   output logic              rsp_nmi_armed
);
   localparam int NT_AW  = vprf_pkg::NT_AW;
   localparam int PAT_AW = vprf_pkg::PAT_AW;
   localparam int SPR_AW = vprf_pkg::SPR_AW;

   logic [7:0]  regs_ff [8];
   logic [15:0] v_ff, t_ff;
   logic [2:0]  fx_ff;
   logic        wt_ff;
   logic [7:0]  buf_ff;
   logic [5:0]  inc_ff;
   logic [7:0]  sp_ff;
   logic        vbl_ff;
   logic [8:0]  line_ff;
   logic        valid_ff;
   logic [7:0]  rd_ff;
   // captured item
   logic [2:0]  func_ff, port_ff;
   logic [7:0]  data_ff;
   logic [1:0]  region_ff; // memory region of the access
   logic        pal_hi_ff;

   // address decode on current v at issue time
   logic [13:0] a;
   logic [1:0]  sel;
   logic [11:0] nt_full;
   logic        is_pal, is_pat;
   logic        is_wr, is_data;
   assign a       = v_ff[13:0];
   assign is_pal  = a >= 14'h3F00;
   assign is_pat  = a < 14'h2000;
   assign sel     = nt_map[{a[11:10], 1'b0} +: 2];
   assign nt_full = {sel, a[9:0]};
   assign is_wr   = req_func == vprf_pkg::FUNC_WRITE;
   assign is_data = req_port_index == vprf_pkg::PORT_DATA;

   logic we_pat, we_nt, we_spr, we_bg, we_sp;
   logic [7:0] pat_q, nt_q, spr_q;
   logic [5:0] bg_q, sp_q;
   logic [5:0] bg_pal_ff [16];
   logic [5:0] sp_pal_ff [16];
   assign we_pat = cmd.issue && is_wr && is_data && is_pat;
   assign we_nt  = cmd.issue && is_wr && is_data && !is_pat && !is_pal;
   assign we_spr = cmd.issue && is_wr && req_port_index == vprf_pkg::PORT_SPDATA;
   assign we_bg  = cmd.issue && is_wr && is_data && is_pal && (a[4] == 1'b0 || a[3:0] == 4'd0);
   assign we_sp  = cmd.issue && is_wr && is_data && is_pal && (a[4] == 1'b1 || a[3:0] == 4'd0);

   vprf_ram #(.WIDTH(8), .DEPTH(vprf_pkg::PATTERN_BYTES)) u_pat (
      .clock(clock), .we(we_pat), .addr(a[PAT_AW-1:0]), .wdata(req_write_data),
      .rdata(pat_q));
   vprf_ram #(.WIDTH(8), .DEPTH(vprf_pkg::NAMETABLE_BYTES)) u_nt (
      .clock(clock), .we(we_nt), .addr(nt_full[NT_AW-1:0]), .wdata(req_write_data),
      .rdata(nt_q));
   vprf_ram #(.WIDTH(8), .DEPTH(vprf_pkg::SPRITE_MEM_BYTES)) u_spr (
      .clock(clock), .we(we_spr), .addr(sp_ff[SPR_AW-1:0]), .wdata(req_write_data),
      .rdata(spr_q));

   // palettes are small register files, read at one decoded address
   logic [5:0] pal_rd_ff;
   always_ff @(posedge clock) begin
      if (we_bg) bg_pal_ff[a[3:0]] <= req_write_data[5:0];
      if (we_sp) sp_pal_ff[a[3:0]] <= req_write_data[5:0];
      pal_rd_ff <= a[4] ? sp_pal_ff[a[3:0]] : bg_pal_ff[a[3:0]];
   end
   assign bg_q = pal_rd_ff;
   assign sp_q = pal_rd_ff;

   // scanline next-line rule
   logic [15:0] ln_v, ln_out;
   always_comb begin
      ln_v = (v_ff & 16'hFBE0) | (t_ff & 16'h041F);
      ln_out = ln_v + 16'h1000;
      if ((ln_v & 16'h7000) == 16'h7000) begin
         ln_out = ln_v & 16'h8FFF;
         if ((ln_out & 16'h03E0) == 16'h03A0) ln_out = (ln_out ^ 16'h0800) & 16'hFC1F;
         else if ((ln_out & 16'h03E0) == 16'h03E0) ln_out = ln_out & 16'hFC1F;
         else ln_out = ln_out + 16'h0020;
      end
   end

   logic rend;
   assign rend = (regs_ff[1] & 8'h18) != 8'h00;
   logic [15:0] t_tmp;
   logic        wt_n;

   // status value as it was at issue (before clearing bit 7)
   logic [7:0] data_ff_status, status_snap_ff;
   always_ff @(posedge clock) begin
      if (cmd.issue) status_snap_ff <= regs_ff[2];
   end
   assign data_ff_status = status_snap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) regs_ff[i] <= 8'h00;
         v_ff <= '0; t_ff <= '0; fx_ff <= '0; wt_ff <= 1'b0; buf_ff <= '0;
         inc_ff <= '0; sp_ff <= '0; vbl_ff <= 1'b0; line_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.finish;
         if (cmd.issue) begin
            func_ff   <= req_func;
            port_ff   <= req_port_index;
            data_ff   <= req_write_data;
            region_ff <= is_pal ? vprf_pkg::REGION_PAL :
                         (is_pat ? vprf_pkg::REGION_PAT : vprf_pkg::REGION_NT);
            pal_hi_ff <= a[4];
            unique case (req_func)
               vprf_pkg::FUNC_READ: begin
                  if (req_port_index == vprf_pkg::PORT_STATUS) begin
                     wt_ff <= 1'b0;
                     regs_ff[2] <= regs_ff[2] & 8'h7F;
                  end else if (is_data) begin
                     v_ff <= v_ff + {10'd0, inc_ff};
                  end
               end
               vprf_pkg::FUNC_WRITE: begin
                  regs_ff[req_port_index] <= req_write_data;
                  unique case (req_port_index)
                     vprf_pkg::PORT_CTRL: begin
                        inc_ff <= req_write_data[2] ? 6'd32 : 6'd1;
                        t_ff <= (t_ff & 16'hF3FF) | {4'd0, req_write_data[1:0], 10'd0};
                     end
                     vprf_pkg::PORT_SPADDR: sp_ff <= req_write_data;
                     vprf_pkg::PORT_SPDATA: sp_ff <= sp_ff + 8'd1;
                     vprf_pkg::PORT_SCROLL: begin
                        wt_ff <= ~wt_ff;
                        if (!wt_ff) begin
                           t_ff <= {t_ff[15:5], req_write_data[7:3]};
                           fx_ff <= req_write_data[2:0];
                        end else begin
                           t_ff <= {t_ff[15], req_write_data[2:0], t_ff[11:10],
                                    req_write_data[7:3], t_ff[4:0]};
                        end
                     end
                     vprf_pkg::PORT_ADDR: begin
                        wt_ff <= ~wt_ff;
                        if (!wt_ff) t_ff <= {2'b00, req_write_data[5:0], t_ff[7:0]};
                        else begin
                           t_ff <= {t_ff[15:8], req_write_data};
                           v_ff <= {t_ff[15:8], req_write_data};
                        end
                     end
                     vprf_pkg::PORT_DATA: v_ff <= v_ff + {10'd0, inc_ff};
                     default: ;
                  endcase
               end
               vprf_pkg::FUNC_FRAME: begin
                  line_ff <= '0;
                  if (rend) v_ff <= t_ff;
               end
               vprf_pkg::FUNC_LINE: begin
                  if (rend) v_ff <= ln_out;
                  line_ff <= line_ff + 9'd1;
               end
               vprf_pkg::FUNC_VBL_ON: begin
                  vbl_ff <= 1'b1;
                  regs_ff[2] <= regs_ff[2] | 8'h80;
               end
               vprf_pkg::FUNC_VBL_OFF: begin
                  vbl_ff <= 1'b0;
                  regs_ff[2] <= regs_ff[2] & 8'h3F;
               end
               default: ;
            endcase
         end
         if (cmd.finish) begin
            priority if (func_ff != vprf_pkg::FUNC_READ) rd_ff <= 8'h00;
            else if (port_ff == vprf_pkg::PORT_DATA && region_ff == vprf_pkg::REGION_PAL)
               rd_ff <= {2'b00, pal_hi_ff ? sp_q : bg_q};
            else if (port_ff == vprf_pkg::PORT_DATA) begin
               rd_ff <= buf_ff;
               buf_ff <= (region_ff == vprf_pkg::REGION_PAT) ? pat_q : nt_q;
            end else if (port_ff == vprf_pkg::PORT_STATUS) rd_ff <= data_ff_status;
            else rd_ff <= regs_ff[port_ff];
         end
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_read_data     = rd_ff;
   assign rsp_vblank_active = vbl_ff;
   assign rsp_nmi_armed     = regs_ff[0][7];
   // sprite memory is write-only from the ports
   logic unused_spr;
   assign unused_spr = ^{spr_q, t_tmp, wt_n, line_ff, fx_ff};
   assign t_tmp = t_ff;
   assign wt_n  = wt_ff;
endmodule

// ----- hdl/video_port_register_file.sv -----
// Top level of the video port register file.
`timescale 1ns / 1ps
// Command-style block: an item is taken when start is high and busy is low.
// busy stays high through the EXEC state after the transfer, in which the
// synchronous memory reads complete, so a new item is not taken until the
// last one is through. The result sits on the rsp_ ports for one cycle with
// rsp_valid high, registered after the EXEC state. The receiver cannot stall.
// The nametable map register is written over the csr_ channel, which is
// always ready.
module video_port_register_file (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_func,
   input  logic [2:0] req_port_index,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_data,
   output logic       rsp_vblank_active,
   output logic       rsp_nmi_armed,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);
   vprf_pkg::cmd_type cmd;
   logic [7:0] nt_map_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) nt_map_ff <= 8'd68;
      else if (csr_valid) nt_map_ff <= csr_data;
   end

   vprf_ctrl u_ctrl (.clock(clock), .reset(reset), .start(start), .busy(busy), .cmd(cmd));

   vprf_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_func(req_func), .req_port_index(req_port_index),
      .req_write_data(req_write_data), .nt_map(nt_map_ff),
      .rsp_valid(rsp_valid), .rsp_read_data(rsp_read_data),
      .rsp_vblank_active(rsp_vblank_active), .rsp_nmi_armed(rsp_nmi_armed));
endmodule

// ----- bench/video_port_register_file_tb.sv -----
// Self-checking testbench for the video port register file.
`timescale 1ns / 1ps
module video_port_register_file_tb;
   typedef struct {
      logic [2:0] func;
      logic [2:0] port;
      logic [7:0] data;
   } bus_item_type;

   typedef struct {
      logic [7:0] read_data;
      logic       vblank;
      logic       nmi;
   } bus_result_type;

   localparam int PAL_BASE    = vprf_pkg::NAMETABLE_BYTES + vprf_pkg::PATTERN_BYTES;
   localparam int CYCLE_LIMIT = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [2:0] req_func = '0;
   logic [2:0] req_port_index = '0;
   logic [7:0] req_write_data = '0;
   logic       rsp_valid;
   logic [7:0] rsp_read_data;
   logic       rsp_vblank_active;
   logic       rsp_nmi_armed;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = '0;

   video_port_register_file u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_port_index(req_port_index),
      .req_write_data(req_write_data),
      .rsp_valid(rsp_valid), .rsp_read_data(rsp_read_data),
      .rsp_vblank_active(rsp_vblank_active), .rsp_nmi_armed(rsp_nmi_armed),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // shadow copy of the block state
   logic [7:0]  sh_regs [8];
   logic [15:0] sh_v, sh_t;
   logic [2:0]  sh_fine_x;
   logic        sh_toggle;
   logic [7:0]  sh_rdbuf;
   logic [5:0]  sh_inc;
   logic [7:0]  sh_sprite_ptr;
   logic        sh_vblank;
   logic [8:0]  sh_line;
   logic [7:0]  sh_nt_map;
   logic [7:0]  sh_pattern [vprf_pkg::PATTERN_BYTES];
   logic [7:0]  sh_nametable [vprf_pkg::NAMETABLE_BYTES];
   logic [5:0]  sh_bg_pal [16];
   logic [5:0]  sh_spr_pal [16];
   bit          written [PAL_BASE + 32];

   bus_item_type   pending_items[$];
   bus_result_type expected_results[$];
   int          errors = 0;
   int          cycles = 0;
   int          max_gap = 10;
   int          gap = 0;

   // flat index: pattern, then physical nametable, then bg/sprite palette
   function automatic int unsigned locate(input logic [15:0] v);
      logic [15:0] a;
      logic [1:0]  sel;
      a = v & 16'h3FFF;
      if (a >= 16'h3F00) return PAL_BASE + (a[4] ? 16 : 0) + a[3:0];
      if (a >= 16'h3000) a = a & 16'hEFFF;
      if (a < 16'h2000) return a % vprf_pkg::PATTERN_BYTES;
      sel = sh_nt_map[{a[11:10], 1'b0} +: 2];
      return vprf_pkg::PATTERN_BYTES + ({sel, a[9:0]} % vprf_pkg::NAMETABLE_BYTES);
   endfunction

   function automatic logic [7:0] mem_read(input int unsigned idx);
      if (idx < vprf_pkg::PATTERN_BYTES) return sh_pattern[idx];
      if (idx < PAL_BASE) return sh_nametable[idx - vprf_pkg::PATTERN_BYTES];
      if (idx < PAL_BASE + 16) return {2'b00, sh_bg_pal[idx - PAL_BASE]};
      return {2'b00, sh_spr_pal[idx - PAL_BASE - 16]};
   endfunction

   task automatic mem_write(input int unsigned idx, input logic [7:0] d);
      if (idx < vprf_pkg::PATTERN_BYTES) sh_pattern[idx] = d;
      else if (idx < PAL_BASE) sh_nametable[idx - vprf_pkg::PATTERN_BYTES] = d;
      else if (idx == PAL_BASE || idx == PAL_BASE + 16) begin
         sh_bg_pal[0] = d[5:0];
         sh_spr_pal[0] = d[5:0];
         written[PAL_BASE] = 1'b1;
         written[PAL_BASE + 16] = 1'b1;
      end else if (idx < PAL_BASE + 16) sh_bg_pal[idx - PAL_BASE] = d[5:0];
      else sh_spr_pal[idx - PAL_BASE - 16] = d[5:0];
      written[idx] = 1'b1;
   endtask

   function automatic logic render_on();
      return sh_regs[vprf_pkg::PORT_MASK][4] | sh_regs[vprf_pkg::PORT_MASK][3];
   endfunction

   task automatic apply_item(input bus_item_type it, output bus_result_type res);
      int unsigned idx;
      logic [15:0] nv;
      res.read_data = 8'h00;
      case (it.func)
         vprf_pkg::FUNC_READ: begin
            if (it.port == vprf_pkg::PORT_STATUS) begin
               sh_toggle = 1'b0;
               res.read_data = sh_regs[vprf_pkg::PORT_STATUS];
               sh_regs[vprf_pkg::PORT_STATUS][7] = 1'b0;
            end else if (it.port == vprf_pkg::PORT_DATA) begin
               idx = locate(sh_v);
               sh_v = sh_v + {10'd0, sh_inc};
               if (idx >= PAL_BASE) res.read_data = mem_read(idx);
               else begin
                  res.read_data = sh_rdbuf;
                  sh_rdbuf = mem_read(idx);
               end
            end else res.read_data = sh_regs[it.port];
         end
         vprf_pkg::FUNC_WRITE: begin
            sh_regs[it.port] = it.data;
            case (it.port)
               vprf_pkg::PORT_CTRL: begin
                  sh_inc = it.data[2] ? 6'd32 : 6'd1;
                  sh_t[11:10] = it.data[1:0];
               end
               vprf_pkg::PORT_SPADDR: sh_sprite_ptr = it.data;
               vprf_pkg::PORT_SPDATA: sh_sprite_ptr = sh_sprite_ptr + 8'd1;
               vprf_pkg::PORT_SCROLL: begin
                  sh_toggle = ~sh_toggle;
                  if (sh_toggle) begin
                     sh_t[4:0] = it.data[7:3];
                     sh_fine_x = it.data[2:0];
                  end else begin
                     sh_t[9:5] = it.data[7:3];
                     sh_t[14:12] = it.data[2:0];
                  end
               end
               vprf_pkg::PORT_ADDR: begin
                  sh_toggle = ~sh_toggle;
                  if (sh_toggle) sh_t[15:8] = {2'b00, it.data[5:0]};
                  else begin
                     sh_t[7:0] = it.data;
                     sh_v = sh_t;
                  end
               end
               vprf_pkg::PORT_DATA: begin
                  idx = locate(sh_v);
                  sh_v = sh_v + {10'd0, sh_inc};
                  mem_write(idx, (idx >= PAL_BASE) ? (it.data & 8'h3F) : it.data);
               end
               default: ;
            endcase
         end
         vprf_pkg::FUNC_FRAME: begin
            sh_line = '0;
            if (render_on()) sh_v = sh_t;
         end
         vprf_pkg::FUNC_LINE: begin
            if (render_on()) begin
               nv = (sh_v & 16'hFBE0) | (sh_t & 16'h041F);
               if ((nv & 16'h7000) == 16'h7000) begin
                  nv = nv & 16'h8FFF;
                  if ((nv & 16'h03E0) == 16'h03A0) nv = (nv ^ 16'h0800) & 16'hFC1F;
                  else if ((nv & 16'h03E0) == 16'h03E0) nv = nv & 16'hFC1F;
                  else nv = nv + 16'h0020;
               end else nv = nv + 16'h1000;
               sh_v = nv;
            end
            sh_line = sh_line + 9'd1;
         end
         vprf_pkg::FUNC_VBL_ON: begin
            sh_vblank = 1'b1;
            sh_regs[vprf_pkg::PORT_STATUS][7] = 1'b1;
         end
         vprf_pkg::FUNC_VBL_OFF: begin
            sh_vblank = 1'b0;
            sh_regs[vprf_pkg::PORT_STATUS] = sh_regs[vprf_pkg::PORT_STATUS] & 8'h3F;
         end
         default: ;
      endcase
      res.vblank = sh_vblank;
      res.nmi = sh_regs[vprf_pkg::PORT_CTRL][7];
   endtask

   // queue one item; a data read that would hit a never-written cell becomes a write
   task automatic add_item(input logic [2:0] f, input logic [2:0] p, input logic [7:0] d);
      bus_item_type   it;
      bus_result_type res;
      it.func = f;
      it.port = p;
      it.data = d;
      if (f == vprf_pkg::FUNC_READ && p == vprf_pkg::PORT_DATA && !written[locate(sh_v)])
         it.func = vprf_pkg::FUNC_WRITE;
      apply_item(it, res);
      pending_items.push_back(it);
      expected_results.push_back(res);
   endtask

   task automatic set_address(input logic [13:0] a);
      add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_ADDR, {2'b00, a[13:8]});
      add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_ADDR, a[7:0]);
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || expected_results.size() != 0 || start)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_nt_map(input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sh_nt_map = value;
   endtask

   task automatic random_items(input int count);
      int k;
      logic [13:0] a;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 99);
         if (k < 10) begin
            case ($urandom_range(0, 3))
               0: a = 14'($urandom_range(14'h0000, 14'h1FFF));
               1: a = 14'($urandom_range(14'h2000, 14'h2FFF));
               2: a = 14'($urandom_range(14'h3000, 14'h3EFF));
               default: a = 14'($urandom_range(14'h3F00, 14'h3FFF));
            endcase
            set_address(a);
         end else if (k < 40) add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_DATA, 8'($urandom));
         else if (k < 60) add_item(vprf_pkg::FUNC_READ, vprf_pkg::PORT_DATA, 8'($urandom));
         else if (k < 64) add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_CTRL, 8'($urandom));
         else if (k < 68) add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_MASK, 8'($urandom));
         else if (k < 74) add_item(vprf_pkg::FUNC_READ, 3'($urandom), 8'($urandom));
         else if (k < 79) add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_SCROLL, 8'($urandom));
         else if (k < 87)
            add_item(3'($urandom_range(vprf_pkg::FUNC_FRAME, vprf_pkg::FUNC_VBL_OFF)),
                     3'($urandom), 8'($urandom));
         else if (k < 89) add_item(3'($urandom_range(6, 7)), 3'($urandom), 8'($urandom));
         else if (k < 94)
            add_item(vprf_pkg::FUNC_WRITE,
                     3'($urandom_range(vprf_pkg::PORT_SPADDR, vprf_pkg::PORT_SPDATA)),
                     8'($urandom));
         else add_item(3'($urandom), 3'($urandom), 8'($urandom));
      end
   endtask

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
   endtask

   // driver
   always @(posedge clock) begin
      logic go;
      bus_item_type it;
      go = start;
      if (reset) go = 1'b0;
      else begin
         if (start && !busy) go = 1'b0;
         if (!go) begin
            if (gap > 0) gap <= gap - 1;
            else if (pending_items.size() != 0) begin
               it = pending_items.pop_front();
               req_func <= it.func;
               req_port_index <= it.port;
               req_write_data <= it.data;
               go = 1'b1;
               gap <= $urandom_range(0, max_gap);
            end
         end
      end
      start <= go;
   end

   // monitor
   always @(posedge clock) begin
      bus_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) report("unexpected transfer", rsp_read_data, 8'h00);
         else begin
            want = expected_results.pop_front();
            if (rsp_read_data !== want.read_data)
               report("read_data", rsp_read_data, want.read_data);
            if (rsp_vblank_active !== want.vblank)
               report("vblank_active", {7'd0, rsp_vblank_active}, {7'd0, want.vblank});
            if (rsp_nmi_armed !== want.nmi)
               report("nmi_armed", {7'd0, rsp_nmi_armed}, {7'd0, want.nmi});
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** video_port_register_file: FAILED **");
         $finish;
      end
   end

   initial begin
      foreach (sh_regs[i]) sh_regs[i] = '0;
      sh_v = '0; sh_t = '0; sh_fine_x = '0; sh_toggle = 1'b0; sh_rdbuf = '0;
      sh_inc = '0; sh_sprite_ptr = '0; sh_vblank = 1'b0; sh_line = '0;
      sh_nt_map = 8'd68;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every func and port, palette sharing, pointer wrap
      add_item(vprf_pkg::FUNC_READ, vprf_pkg::PORT_CTRL, 8'h00);
      add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_CTRL, 8'hFF);
      add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_CTRL, 8'h00);
      add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_MASK, 8'hFF);
      add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_STATUS, 8'hFF);
      add_item(vprf_pkg::FUNC_READ, vprf_pkg::PORT_STATUS, 8'h00);
      add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_SPADDR, 8'hFF);
      add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_SPDATA, 8'hA5);
      add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_SPDATA, 8'h5A);
      add_item(vprf_pkg::FUNC_READ, vprf_pkg::PORT_SPADDR, 8'h00);
      set_address(14'h3F00);
      add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_DATA, 8'hFF);
      set_address(14'h3F10);
      add_item(vprf_pkg::FUNC_READ, vprf_pkg::PORT_DATA, 8'h00);
      add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_SCROLL, 8'hFF);
      add_item(vprf_pkg::FUNC_WRITE, vprf_pkg::PORT_SCROLL, 8'hFF);
      add_item(vprf_pkg::FUNC_VBL_ON, 3'd7, 8'hFF);
      add_item(vprf_pkg::FUNC_READ, vprf_pkg::PORT_STATUS, 8'h00);
      add_item(vprf_pkg::FUNC_FRAME, 3'd0, 8'h00);
      add_item(vprf_pkg::FUNC_LINE, 3'd0, 8'h00);
      add_item(vprf_pkg::FUNC_VBL_OFF, 3'd0, 8'h00);
      add_item(3'd6, 3'd7, 8'hFF);
      add_item(3'd7, 3'd0, 8'h00);
      wait_idle();

      // random phases across mapping settings; each write happens with the block idle
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_nt_map(8'h00);
            1: write_nt_map(8'hFF);
            2: write_nt_map(8'hE4);
            default: write_nt_map(8'($urandom));
         endcase
         max_gap = (ph == 3) ? 0 : 10;
         random_items(200);
         wait_idle();
      end

      if (errors == 0) $display("** video_port_register_file: PASSED **");
      else $display("** video_port_register_file: FAILED **");
      $finish;
   end
endmodule

// ----- sim.f -----
hdl/vprf_pkg.sv
hdl/vprf_ram.sv
hdl/vprf_ctrl.sv
hdl/vprf_datapath.sv
hdl/video_port_register_file.sv
bench/video_port_register_file_tb.sv
